### sv/lhp_pkg.sv
// Shared types and constants of the latency histogram block.
`default_nettype none
package lhp_pkg;

    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_BKT,
        S_RD,
        S_WR,
        S_WRD,
        S_WACC,
        S_WCMP,
        S_FIN,
        S_RESP
    } t_state;

    // One classified item as it waits in the queue
    typedef struct packed {
        t_cmd        cmd;
        logic [2:0]  metric;
        logic        metric_ok;
        logic [31:0] value;
        logic [6:0]  pct;
    } t_item;

    localparam logic [6:0] PCT_MAX   = 7'd100;
    localparam int         QUEUE_LEN = 2;

endpackage
`default_nettype wire

### sv/lhp_front.sv
// Front part: classify incoming transfers and hold them in a short queue.
`default_nettype none
module lhp_front #(
    parameter int METRICS = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [1:0]    i_cmd,
    input  wire logic [2:0]    i_metric,
    input  wire logic [39:0]   i_value_us,
    input  wire logic [6:0]    i_percent,
    output lhp_pkg::t_item     o_head,
    output logic               o_head_valid,
    input  wire logic          i_pop
);
    import lhp_pkg::*;

    t_item       r_q [QUEUE_LEN];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_item       item;
    logic        keep;
    logic        push;

    always_comb begin
        item.cmd       = t_cmd'(i_cmd);
        item.metric    = i_metric;
        item.metric_ok = ({1'b0, i_metric} < 4'(METRICS));
        item.value     = (|i_value_us[39:32]) ? 32'hFFFF_FFFF : i_value_us[31:0];
        item.pct       = (i_percent > PCT_MAX) ? PCT_MAX : i_percent;
        // drop records to absent metrics and the unused code
        keep = (item.cmd == CMD_RECORD && item.metric_ok) ||
               item.cmd == CMD_QUERY || item.cmd == CMD_CLEAR;
    end

    assign o_ready      = (r_cnt != 2'(QUEUE_LEN));
    assign push         = i_valid && o_ready && keep;
    assign o_head       = r_q[r_rp];
    assign o_head_valid = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= item;
                r_wp      <= ~r_wp;
            end
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

### sv/lhp_back.sv
// Back part: bucket store, statistics, record update and percentile walk.
`default_nettype none
module lhp_back #(
    parameter int METRICS        = 6,
    parameter int FINE_BUCKETS   = 64,
    parameter int COARSE_BUCKETS = 63
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  lhp_pkg::t_item     i_head,
    input  wire logic          i_head_valid,
    output logic               o_pop,
    input  wire logic [15:0]   i_fine_w,
    input  wire logic [19:0]   i_coarse_w,
    input  wire logic [31:0]   i_span,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [31:0]        o_percentile_us,
    output logic [31:0]        o_min_us,
    output logic [31:0]        o_max_us,
    output logic [31:0]        o_sample_count,
    output logic [47:0]        o_total_us
);
    import lhp_pkg::*;

    localparam int BPM   = FINE_BUCKETS + COARSE_BUCKETS + 1;
    localparam int BW    = $clog2(BPM);
    localparam int MW    = (METRICS > 1) ? $clog2(METRICS) : 1;
    localparam int AW    = MW + BW;
    localparam int DEPTH = METRICS << BW;
    localparam int MAXFC = (FINE_BUCKETS > COARSE_BUCKETS) ? FINE_BUCKETS : COARSE_BUCKETS;
    localparam int QB    = $clog2(MAXFC + 1);
    localparam int SBW   = $clog2(QB + 1);
    localparam int CW    = (20 + QB + 1 > 32) ? 20 + QB + 1 : 32;
    localparam int SW    = 32 + BW + 7;

    t_state r_state, n_state;

    logic [31:0]   r_mem [DEPTH];
    logic [31:0]   r_rdata;
    logic          mem_we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata;

    logic [31:0]   r_min [METRICS];
    logic [31:0]   r_max [METRICS];
    logic [47:0]   r_sum [METRICS];
    logic [31:0]   r_cnt [METRICS];

    logic [AW-1:0]  r_caddr;
    logic [MW-1:0]  r_m;
    logic [BW-1:0]  r_b;
    logic [31:0]    r_rem;
    logic [19:0]    r_div;
    logic [QB-1:0]  r_q;
    logic [SBW-1:0] r_step;
    logic           r_fine_mode;
    logic [38:0]    r_x;
    logic [SW-1:0]  r_seen;
    logic [31:0]    r_edge;

    logic [31:0]    r_res_pct, r_res_min, r_res_max, r_res_cnt;
    logic [47:0]    r_res_sum;

    logic [CW-1:0]  div_sh;
    logic           div_ge;
    logic           div_top;
    logic [MW-1:0]  hm;
    logic [SW-1:0]  rd100;
    logic           hit;

    assign hm      = i_head.metric[MW-1:0];
    assign div_sh  = CW'(r_div) << r_step;
    assign div_ge  = (CW'(r_rem) >= div_sh);
    assign div_top = (r_step == SBW'(QB));
    assign rd100   = (SW'(r_rdata) << 6) + (SW'(r_rdata) << 5) + (SW'(r_rdata) << 2);
    assign hit     = (r_seen >= SW'(r_x));
    assign raddr   = {r_m, r_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        mem_we  = 1'b0;
        waddr   = {r_m, r_b};
        wdata   = r_rdata + 32'd1;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                waddr  = r_caddr;
                wdata  = 32'd0;
                if (r_caddr == AW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_head_valid) begin
                    o_pop = 1'b1;
                    case (i_head.cmd)
                        CMD_RECORD: n_state = S_DIV;
                        CMD_QUERY: begin
                            if (!i_head.metric_ok || r_cnt[hm] == 32'd0 ||
                                i_head.pct == 7'd0) n_state = S_RESP;
                            else n_state = S_WRD;
                        end
                        CMD_CLEAR: n_state = S_CLEAR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_DIV: begin
                if ((div_ge && div_top) || (r_step == '0)) n_state = S_BKT;
            end
            S_BKT:  n_state = S_RD;
            S_RD:   n_state = S_WR;
            S_WR: begin
                mem_we  = 1'b1;
                n_state = S_IDLE;
            end
            S_WRD:  n_state = S_WACC;
            S_WACC: n_state = S_WCMP;
            S_WCMP: begin
                if (hit)                      n_state = S_FIN;
                else if (r_b == BW'(BPM - 2)) n_state = S_RESP;
                else                          n_state = S_WRD;
            end
            S_FIN:  n_state = S_RESP;
            S_RESP: if (!o_valid) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caddr <= '0;
            o_valid <= 1'b0;
            for (int i = 0; i < METRICS; i++) begin
                r_min[i] <= '0;
                r_max[i] <= '0;
                r_sum[i] <= '0;
                r_cnt[i] <= '0;
            end
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_state)
                S_CLEAR: r_caddr <= r_caddr + AW'(1);
                S_IDLE: begin
                    if (i_head_valid) begin
                        r_m <= hm;
                        r_b <= '0;
                        case (i_head.cmd)
                            CMD_RECORD: begin
                                r_step <= SBW'(QB);
                                r_q    <= '0;
                                if (i_head.value < i_span) begin
                                    r_fine_mode <= 1'b1;
                                    r_rem       <= i_head.value;
                                    r_div       <= 20'(i_fine_w);
                                end else begin
                                    r_fine_mode <= 1'b0;
                                    r_rem       <= i_head.value - i_span;
                                    r_div       <= i_coarse_w;
                                end
                                if (r_cnt[hm] == 32'd0 || i_head.value < r_min[hm])
                                    r_min[hm] <= i_head.value;
                                if (i_head.value > r_max[hm]) r_max[hm] <= i_head.value;
                                r_sum[hm] <= r_sum[hm] + 48'(i_head.value);
                                r_cnt[hm] <= r_cnt[hm] + 32'd1;
                            end
                            CMD_QUERY: begin
                                r_seen <= '0;
                                r_edge <= 32'(i_fine_w);
                                if (!i_head.metric_ok || r_cnt[hm] == 32'd0) begin
                                    r_res_pct <= '0;
                                    r_res_min <= '0;
                                    r_res_max <= '0;
                                    r_res_cnt <= '0;
                                    r_res_sum <= '0;
                                end else begin
                                    r_x       <= 39'(r_cnt[hm]) * 39'(i_head.pct);
                                    r_res_pct <= r_max[hm];
                                    r_res_min <= r_min[hm];
                                    r_res_max <= r_max[hm];
                                    r_res_cnt <= r_cnt[hm];
                                    r_res_sum <= r_sum[hm];
                                end
                            end
                            CMD_CLEAR: begin
                                r_caddr <= '0;
                                for (int i = 0; i < METRICS; i++) begin
                                    r_min[i] <= '0;
                                    r_max[i] <= '0;
                                    r_sum[i] <= '0;
                                    r_cnt[i] <= '0;
                                end
                            end
                            default: r_caddr <= r_caddr;
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_ge && div_top) begin
                        r_q <= '1;
                    end else begin
                        if (div_ge) begin
                            r_rem <= r_rem - div_sh[31:0];
                            r_q   <= r_q | (QB'(1) << r_step);
                        end
                        if (r_step != '0) r_step <= r_step - SBW'(1);
                    end
                end
                S_BKT: begin
                    if (r_fine_mode)                         r_b <= BW'(r_q);
                    else if (32'(r_q) < COARSE_BUCKETS)      r_b <= BW'(FINE_BUCKETS) + BW'(r_q);
                    else                                     r_b <= BW'(FINE_BUCKETS + COARSE_BUCKETS);
                end
                S_WACC: r_seen <= r_seen + rd100;
                S_WCMP: begin
                    if (!hit) begin
                        r_b <= r_b + BW'(1);
                        if (32'(r_b) + 32'd1 < FINE_BUCKETS) r_edge <= r_edge + 32'(i_fine_w);
                        else                                 r_edge <= r_edge + 32'(i_coarse_w);
                    end
                end
                S_FIN: begin
                    if (r_edge < r_res_min)      r_res_pct <= r_res_min;
                    else if (r_edge > r_res_max) r_res_pct <= r_res_max;
                    else                         r_res_pct <= r_edge;
                end
                S_RESP: begin
                    if (!o_valid) begin
                        o_valid         <= 1'b1;
                        o_percentile_us <= r_res_pct;
                        o_min_us        <= r_res_min;
                        o_max_us        <= r_res_max;
                        o_sample_count  <= r_res_cnt;
                        o_total_us      <= r_res_sum;
                    end
                end
                default: r_caddr <= r_caddr;
            endcase
        end
    end
endmodule
`default_nettype wire

### sv/latency_histogram_percentile.sv
// Top level: configuration registers, front queue and back engine of the histogram.
// Record: from the queue head through the one-bit-a-cycle bucket divider, then bucket
//   select, bucket store read and incremented write-back.
// Query: buckets are read, added up and compared in turn through the one store read port.
// Reset and clear: a sweep over METRICS*2^ceil(log2(buckets)) words (768 at the defaults)
//   zeroes the bucket store; items queue in front meanwhile, configuration stays open.
`default_nettype none
module latency_histogram_percentile #(
    parameter int METRICS        = 6,
    parameter int FINE_BUCKETS   = 64,
    parameter int COARSE_BUCKETS = 63
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [2:0]  i_metric,
    input  wire logic [39:0] i_value_us,
    input  wire logic [6:0]  i_percent,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_percentile_us,
    output logic [31:0]      o_min_us,
    output logic [31:0]      o_max_us,
    output logic [31:0]      o_sample_count,
    output logic [47:0]      o_total_us,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import lhp_pkg::*;

    logic [15:0] r_fine;
    logic [19:0] r_coarse;
    logic [31:0] r_span;
    logic [15:0] fine_w;
    logic [19:0] coarse_w;
    t_item       head;
    logic        head_valid;
    logic        pop;

    // A zero width behaves as a width of one
    assign fine_w   = (r_fine == 16'd0) ? 16'd1 : r_fine;
    assign coarse_w = (r_coarse == 20'd0) ? 20'd1 : r_coarse;

    assign pready = 1'b1;
    // Decode on bit 2 only: word 0 is the fine width, word 1 the coarse width
    assign prdata = paddr[2] ? {12'd0, r_coarse} : {16'd0, r_fine};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fine   <= 16'd1000;
            r_coarse <= 20'd10000;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) r_coarse <= pwdata[19:0];
            else          r_fine   <= pwdata[15:0];
        end
    end

    // Hold the fine span registered; it settles while the port is idle
    always_ff @(posedge i_clk) begin
        r_span <= 32'(fine_w) * 32'(FINE_BUCKETS);
    end

    lhp_front #(
        .METRICS (METRICS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_metric     (i_metric),
        .i_value_us   (i_value_us),
        .i_percent    (i_percent),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop)
    );

    lhp_back #(
        .METRICS        (METRICS),
        .FINE_BUCKETS   (FINE_BUCKETS),
        .COARSE_BUCKETS (COARSE_BUCKETS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_head_valid    (head_valid),
        .o_pop           (pop),
        .i_fine_w        (fine_w),
        .i_coarse_w      (coarse_w),
        .i_span          (r_span),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_percentile_us (o_percentile_us),
        .o_min_us        (o_min_us),
        .o_max_us        (o_max_us),
        .o_sample_count  (o_sample_count),
        .o_total_us      (o_total_us)
    );
endmodule
`default_nettype wire

### tb/sv/tb_latency_histogram_percentile.sv
// Self-checking testbench for the two-tier latency histogram with percentile queries.
`timescale 1ns / 1ps
`default_nettype none
module tb_latency_histogram_percentile;
    import lhp_pkg::*;

    localparam int METRICS        = 6;
    localparam int FINE_BUCKETS   = 64;
    localparam int COARSE_BUCKETS = 63;
    localparam int BUCKETS        = FINE_BUCKETS + COARSE_BUCKETS + 1;
    localparam int ADDR_FINE      = 0;
    localparam int ADDR_COARSE    = 4;
    // Longest silent stretch: a clear sweep, a full walk and the pressure hold fit well within
    localparam int WATCHDOG_LIMIT = 20000;
    // Cycles to let pass after the last result before touching the registers
    localparam int DRAIN_CYCLES   = 3000;

    typedef struct packed {
        logic [31:0] pct;
        logic [31:0] min;
        logic [31:0] max;
        logic [31:0] cnt;
        logic [47:0] total;
    } t_stats;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_cmd        i_cmd;
    logic [2:0]  i_metric;
    logic [39:0] i_value_us;
    logic [6:0]  i_percent;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_percentile_us;
    logic [31:0] o_min_us;
    logic [31:0] o_max_us;
    logic [31:0] o_sample_count;
    logic [47:0] o_total_us;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    latency_histogram_percentile #(
        .METRICS        (METRICS),
        .FINE_BUCKETS   (FINE_BUCKETS),
        .COARSE_BUCKETS (COARSE_BUCKETS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_metric        (i_metric),
        .i_value_us      (i_value_us),
        .i_percent       (i_percent),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_percentile_us (o_percentile_us),
        .o_min_us        (o_min_us),
        .o_max_us        (o_max_us),
        .o_sample_count  (o_sample_count),
        .o_total_us      (o_total_us),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Predicted histogram state, kept in step with every accepted transfer
    logic [15:0] fine_reg;
    logic [19:0] coarse_reg;
    logic [31:0] hist_bucket [METRICS][BUCKETS];
    logic [31:0] hist_min    [METRICS];
    logic [31:0] hist_max    [METRICS];
    logic [47:0] hist_sum    [METRICS];
    logic [31:0] hist_cnt    [METRICS];

    t_stats expected_stats[$];
    int     errors;
    int     quiet_cnt;      // items left for which neither side idles
    int     hold_req;       // receiver hold-off requested by the pressure test
    int     idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] fine_w();
        return (fine_reg == 16'd0) ? 64'd1 : 64'(fine_reg);
    endfunction

    function automatic logic [63:0] coarse_w();
        return (coarse_reg == 20'd0) ? 64'd1 : 64'(coarse_reg);
    endfunction

    function automatic int bucket_of(logic [31:0] v);
        logic [63:0] span;
        logic [63:0] c;
        span = fine_w() * FINE_BUCKETS;
        if (64'(v) < span) return int'(64'(v) / fine_w());
        c = (64'(v) - span) / coarse_w();
        if (c < COARSE_BUCKETS) return FINE_BUCKETS + int'(c);
        return BUCKETS - 1;
    endfunction

    function automatic logic [63:0] bucket_edge(int m, int b);
        if (b < FINE_BUCKETS) return 64'(b + 1) * fine_w();
        if (b < FINE_BUCKETS + COARSE_BUCKETS)
            return fine_w() * FINE_BUCKETS + 64'(b - FINE_BUCKETS + 1) * coarse_w();
        return 64'(hist_max[m]);
    endfunction

    function automatic logic [31:0] percentile_of(int m, logic [6:0] p);
        logic [63:0] rank;
        logic [63:0] seen;
        logic [63:0] e;
        logic [6:0]  pc;
        pc = (p > PCT_MAX) ? PCT_MAX : p;
        rank = (64'(hist_cnt[m]) * 64'(pc) + 64'd99) / 64'd100;
        if (rank == 0) return hist_max[m];
        seen = 0;
        for (int b = 0; b < BUCKETS; b++) begin
            seen += 64'(hist_bucket[m][b]);
            if (seen >= rank) begin
                e = bucket_edge(m, b);
                if (e < 64'(hist_min[m])) return hist_min[m];
                if (e > 64'(hist_max[m])) return hist_max[m];
                return e[31:0];
            end
        end
        return hist_max[m];
    endfunction

    task automatic clear_histograms();
        for (int m = 0; m < METRICS; m++) begin
            for (int b = 0; b < BUCKETS; b++) hist_bucket[m][b] = '0;
            hist_min[m] = '0;
            hist_max[m] = '0;
            hist_sum[m] = '0;
            hist_cnt[m] = '0;
        end
    endtask

    // Apply one accepted item to the predicted state; queue a result for a query
    task automatic update_histogram(t_cmd cmd, logic [2:0] metric, logic [39:0] raw,
                                    logic [6:0] pct);
        logic [31:0] v;
        t_stats      s;
        int          m;
        m = int'(metric);
        case (cmd)
            CMD_RECORD: begin
                if (m < METRICS) begin
                    v = (raw > 40'hFF_FFFF_FFFF >> 8) ? 32'hFFFF_FFFF : raw[31:0];
                    hist_bucket[m][bucket_of(v)] += 32'd1;
                    if (hist_cnt[m] == 0 || v < hist_min[m]) hist_min[m] = v;
                    if (v > hist_max[m]) hist_max[m] = v;
                    hist_sum[m] = hist_sum[m] + 48'(v);
                    hist_cnt[m] += 32'd1;
                end
            end
            CMD_QUERY: begin
                s = '0;
                if (m < METRICS && hist_cnt[m] != 0) begin
                    s.pct   = percentile_of(m, pct);
                    s.min   = hist_min[m];
                    s.max   = hist_max[m];
                    s.cnt   = hist_cnt[m];
                    s.total = hist_sum[m];
                end
                expected_stats.push_back(s);
            end
            CMD_CLEAR: clear_histograms();
            default: ;
        endcase
    endtask

    // Offer one item, holding it until the transfer, and predict on acceptance
    task automatic send_item(t_cmd cmd, logic [2:0] metric, logic [39:0] value,
                             logic [6:0] pct);
        int gap;
        gap = (quiet_cnt > 0) ? 0 : $urandom_range(0, 6);
        if (quiet_cnt > 0) quiet_cnt--;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_metric   <= metric;
        i_value_us <= value;
        i_percent  <= pct;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        update_histogram(cmd, metric, value, pct);
    endtask

    // Drop valid and wait until the block has nothing left in flight
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_stats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(int addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(addr);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_FINE) fine_reg = data[15:0];
        else coarse_reg = data[19:0];
    endtask

    task automatic set_widths(logic [31:0] fine, logic [31:0] coarse);
        wait_idle();
        reg_write(ADDR_FINE, fine);
        reg_write(ADDR_COARSE, coarse);
    endtask

    // Draw a reading that lands in the fine span, the coarse span, overflow or anywhere
    function automatic logic [39:0] draw_value();
        logic [63:0] span_f;
        logic [63:0] span_c;
        logic [63:0] v;
        span_f = fine_w() * FINE_BUCKETS;
        span_c = span_f + coarse_w() * COARSE_BUCKETS;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = 64'($urandom) % span_f;
            4, 5, 6:    v = span_f + ({32'd0, $urandom} % (span_c - span_f));
            7:          v = span_c + 64'($urandom_range(0, 1000));
            8:          v = 64'($urandom);
            default:    v = {$urandom, $urandom};
        endcase
        return v[39:0];
    endfunction

    task automatic test_directed();
        send_item(CMD_QUERY, 3'd0, 40'd0, 7'd50);           // empty histogram
        send_item(CMD_QUERY, 3'd7, 40'd0, 7'd50);           // metric out of range
        send_item(CMD_RECORD, 3'd7, 40'd500, 7'd0);         // ignored record
        send_item(CMD_RECORD, 3'd6, 40'd500, 7'd0);
        send_item(CMD_QUERY, 3'd6, 40'd0, 7'd100);
        send_item(CMD_RECORD, 3'd0, 40'd0, 7'd0);
        send_item(CMD_RECORD, 3'd0, 40'hFF_FFFF_FFFF, 7'h7F); // saturated reading
        send_item(CMD_RECORD, 3'd0, 40'd63_999, 7'd0);
        send_item(CMD_RECORD, 3'd0, 40'd64_000, 7'd0);
        send_item(CMD_RECORD, 3'd0, 40'd693_999, 7'd0);
        send_item(CMD_RECORD, 3'd0, 40'd694_000, 7'd0);     // first overflow reading
        send_item(CMD_RECORD, 3'd5, 40'hFFFF_FFFF, 7'd0);
        send_item(CMD_RECORD, 3'd5, 40'd1, 7'd0);
        send_item(CMD_QUERY, 3'd0, 40'd0, 7'd0);            // rank of zero
        send_item(CMD_QUERY, 3'd0, 40'd0, 7'd1);
        send_item(CMD_QUERY, 3'd0, 40'd0, 7'd50);
        send_item(CMD_QUERY, 3'd0, 40'd0, 7'd99);
        send_item(CMD_QUERY, 3'd0, 40'd0, 7'd100);
        send_item(CMD_QUERY, 3'd0, 40'd0, 7'h7F);           // clamped to 100
        send_item(CMD_QUERY, 3'd5, 40'd0, 7'd50);
        send_item(CMD_NONE, 3'd0, 40'd0, 7'd0);             // unused code
        send_item(CMD_CLEAR, 3'd0, 40'd0, 7'd0);
        send_item(CMD_QUERY, 3'd0, 40'd0, 7'd50);
        send_item(CMD_QUERY, 3'd5, 40'd0, 7'd50);
    endtask

    task automatic test_random(int n);
        int   r;
        t_cmd cmd;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 70) cmd = CMD_RECORD;
            else if (r < 96) cmd = CMD_QUERY;
            else if (r < 97) cmd = CMD_CLEAR;
            else cmd = CMD_NONE;
            if ($urandom_range(0, 19) == 0) quiet_cnt = $urandom_range(5, 20);
            send_item(cmd, ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                       : 3'($urandom_range(0, 5)),
                      draw_value(), 7'($urandom_range(0, 127)));
        end
    endtask

    // Hold the receiver off while the sender keeps offering back-to-back records and queries
    task automatic test_pressure();
        hold_req  = 600;
        quiet_cnt = 24;
        for (int k = 0; k < 24; k++) begin
            send_item((k % 3 == 0) ? CMD_RECORD : CMD_QUERY, 3'(k % METRICS), draw_value(),
                      7'($urandom_range(0, 127)));
        end
    endtask

    // Result checker: compare each transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_stats s;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_stats.size() == 0) begin
                $display("%0t: unexpected result, actual pct=%0d min=%0d max=%0d cnt=%0d sum=%0d",
                         $realtime, o_percentile_us, o_min_us, o_max_us, o_sample_count,
                         o_total_us);
                errors++;
            end else begin
                s = expected_stats.pop_front();
                if (o_percentile_us !== s.pct) begin
                    $display("%0t: percentile expected %0d actual %0d", $realtime, s.pct,
                             o_percentile_us);
                    errors++;
                end
                if (o_min_us !== s.min) begin
                    $display("%0t: min expected %0d actual %0d", $realtime, s.min, o_min_us);
                    errors++;
                end
                if (o_max_us !== s.max) begin
                    $display("%0t: max expected %0d actual %0d", $realtime, s.max, o_max_us);
                    errors++;
                end
                if (o_sample_count !== s.cnt) begin
                    $display("%0t: count expected %0d actual %0d", $realtime, s.cnt,
                             o_sample_count);
                    errors++;
                end
                if (o_total_us !== s.total) begin
                    $display("%0t: total expected %0d actual %0d", $realtime, s.total,
                             o_total_us);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls after each transfer outside quiet stretches, a long hold-off on request
    always @(posedge i_clk) begin
        int stall;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall = 0;
        end else if (hold_req > 0) begin
            i_ready <= 1'b0;
            hold_req--;
        end else if (stall > 0) begin
            i_ready <= 1'b0;
            stall--;
        end else begin
            i_ready <= 1'b1;
            if (o_valid && i_ready && quiet_cnt == 0) stall = $urandom_range(0, 6);
        end
    end

    // Watchdog: count cycles with no transfer on any port
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("latency_histogram_percentile verification failed");
                $finish;
            end
        end
    end

    initial begin
        errors      = 0;
        quiet_cnt   = 0;
        hold_req    = 0;
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_cmd       = CMD_RECORD;
        i_metric    = '0;
        i_value_us  = '0;
        i_percent   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        fine_reg    = 16'd1000;
        coarse_reg  = 20'd10000;
        clear_histograms();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(200);
        test_pressure();
        set_widths(32'd1, 32'd1);
        test_random(200);
        set_widths(32'd65535, 32'd1048575);
        test_random(200);
        set_widths(32'd0, 32'd0);           // zero width behaves as one
        test_random(150);
        set_widths(32'($urandom_range(2, 200)), 32'($urandom_range(2, 5000)));
        test_random(200);
        test_pressure();

        wait_idle();
        if (errors == 0) begin
            $display("latency_histogram_percentile verification clean");
        end else begin
            $display("latency_histogram_percentile verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
